// ===== sv/dmr_pkg.sv =====
// Shared types, constants and helper functions for the dual motor ramp controller.
`timescale 1ns / 1ps

package dmr_pkg;

    // Speed range applied to both channels
    localparam logic signed [7:0] SPEED_MAX = 8'sd100;
    localparam logic signed [7:0] SPEED_MIN = -8'sd100;

    // Ramp interval after reset, in ticks
    localparam logic [15:0] RAMP_INTERVAL_RESET = 16'd10;

    // Brake pulse is speed divided by four: a right shift of the magnitude
    localparam int BRAKE_SHIFT = 2;

    // duty = mag*255/100 computed as (mag * 255 * 5243) >> 19, exact for mag <= 100
    localparam logic [20:0] DUTY_RECIP = 21'd1336965;
    localparam int DUTY_SHIFT = 19;

    // Default queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_SET   = 3'd0,
        OP_RAMP  = 3'd1,
        OP_STOP  = 3'd2,
        OP_BRAKE = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    // Command kinds after classification (stop folds into set with zero speed)
    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_RAMP  = 2'd1,
        CMD_BRAKE = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]        operation;
        logic              channel;
        logic signed [7:0] speed_value;
    } t_in_item;

    typedef struct packed {
        logic              motor;
        logic              direction;
        logic [7:0]        duty;
        logic signed [7:0] current_speed;
        logic              ramping;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              channel;
        logic signed [7:0] speed;
    } t_cmd;

    // Clamp a requested speed to the allowed range
    function automatic logic signed [7:0] sat_speed(input logic signed [7:0] v);
        logic signed [7:0] r;
        r = v;
        if (v > SPEED_MAX) begin
            r = SPEED_MAX;
        end else if (v < SPEED_MIN) begin
            r = SPEED_MIN;
        end
        return r;
    endfunction

    // PWM duty for a speed magnitude of 0..100
    function automatic logic [7:0] duty_of(input logic [6:0] mag);
        logic [27:0] prod;
        prod = 28'(mag) * 28'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: 8];
    endfunction

    // Build one result item from a channel's applied speed
    function automatic t_out_item make_result(
        input logic              ch,
        input logic signed [7:0] speed,
        input logic              active,
        input logic              last
    );
        t_out_item  r;
        logic [7:0] mag;
        mag             = speed[7] ? 8'(-speed) : 8'(speed);
        r.motor         = ch;
        r.direction     = ~speed[7];
        r.duty          = duty_of(mag[6:0]);
        r.current_speed = speed;
        r.ramping       = active;
        r.last          = last;
        return r;
    endfunction

endpackage

// ===== sv/dmr_fifo.sv =====
// Small register-based first-in first-out queue with occupancy count.
`timescale 1ns / 1ps

module dmr_fifo #(
    parameter int DEPTH = dmr_pkg::OUT_DEPTH,
    parameter int WIDTH = $bits(dmr_pkg::t_out_item)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== sv/dmr_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps

module dmr_front #(
    parameter int CMD_DEPTH = dmr_pkg::CMD_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dmr_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output dmr_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid
);

    dmr_pkg::t_cmd cmd;
    logic          cmd_ok;
    logic          cmd_empty;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    logic [$bits(dmr_pkg::t_cmd)-1:0] cmd_rd_bits;

    // Classify the transaction; drop unused operation codes
    always_comb begin
        cmd.channel = i_item.channel;
        cmd.speed   = dmr_pkg::sat_speed(i_item.speed_value);
        cmd.kind    = dmr_pkg::CMD_SET;
        cmd_ok      = 1'b1;
        unique case (dmr_pkg::t_op'(i_item.operation))
            dmr_pkg::OP_SET:   cmd.kind = dmr_pkg::CMD_SET;
            dmr_pkg::OP_RAMP:  cmd.kind = dmr_pkg::CMD_RAMP;
            dmr_pkg::OP_STOP: begin
                cmd.kind  = dmr_pkg::CMD_SET;
                cmd.speed = '0;
            end
            dmr_pkg::OP_BRAKE: cmd.kind = dmr_pkg::CMD_BRAKE;
            dmr_pkg::OP_TICK:  cmd.kind = dmr_pkg::CMD_TICK;
            default:           cmd_ok   = 1'b0;
        endcase
    end

    dmr_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(dmr_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push && cmd_ok),
        .i_wr_data (cmd),
        .i_pop     (i_cmd_pop),
        .o_rd_data (cmd_rd_bits),
        .o_empty   (cmd_empty),
        .o_full    (o_full),
        .o_count   (cmd_count)
    );

    // A command queue that still holds entries has work for the back end
    assign o_cmd       = dmr_pkg::t_cmd'(cmd_rd_bits);
    assign o_cmd_valid = !cmd_empty && (cmd_count != '0);

endmodule

// ===== sv/dmr_back.sv =====
// Back end: holds per-channel motor state, executes commands and builds results.
`timescale 1ns / 1ps

module dmr_back #(
    parameter int OUT_DEPTH = dmr_pkg::OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [15:0]                    i_cfg_wr_data,
    input  dmr_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_res_push,
    output dmr_pkg::t_out_item             o_res
);

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic signed [7:0] r_speed [2];
    logic signed [7:0] n_speed [2];
    logic signed [7:0] r_target [2];
    logic signed [7:0] n_target [2];
    logic              r_active [2];
    logic              n_active [2];
    logic [15:0]       r_tick [2];
    logic [15:0]       n_tick [2];
    logic [15:0]       r_interval;
    logic              r_pend_valid, n_pend_valid;
    logic              r_pend_ch, n_pend_ch;

    logic [15:0]       tick_inc [2];
    logic              step [2];
    logic signed [7:0] step_speed [2];
    logic [7:0]        brake_mag;
    logic [6:0]        brake_q;
    logic signed [7:0] braked;
    logic              take;
    logic              first_vld;
    logic              first_ch;
    logic              first_last;

    // Per-channel tick count and one-unit step toward target
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            tick_inc[c] = (r_tick[c] == 16'hFFFF) ? r_tick[c] : r_tick[c] + 16'd1;
            step[c]     = r_active[c] && (tick_inc[c] >= r_interval);
            if (r_speed[c] < r_target[c]) begin
                step_speed[c] = r_speed[c] + 8'sd1;
            end else if (r_speed[c] > r_target[c]) begin
                step_speed[c] = r_speed[c] - 8'sd1;
            end else begin
                step_speed[c] = r_speed[c];
            end
        end
    end

    // Brake pulse: reverse a quarter of the speed, truncated toward zero
    always_comb begin
        brake_mag = r_speed[i_cmd.channel][7] ? 8'(-r_speed[i_cmd.channel])
                                               : 8'(r_speed[i_cmd.channel]);
        brake_q   = 7'(brake_mag >> dmr_pkg::BRAKE_SHIFT);
        braked    = r_speed[i_cmd.channel][7] ? 8'(signed'({1'b0, brake_q}))
                                               : 8'(-signed'({1'b0, brake_q}));
    end

    // Execute one command when no second result is held and the result queue has room for two entries
    always_comb begin
        n_speed      = r_speed;
        n_target     = r_target;
        n_active     = r_active;
        n_tick       = r_tick;
        n_pend_valid = 1'b0;
        n_pend_ch    = r_pend_ch;
        first_vld    = 1'b0;
        first_ch     = i_cmd.channel;
        first_last   = 1'b1;
        take = i_cmd_valid && !r_pend_valid && (i_out_count <= CW'(OUT_DEPTH - 2));

        if (take) begin
            unique case (i_cmd.kind)
                dmr_pkg::CMD_SET: begin
                    n_speed[i_cmd.channel]  = i_cmd.speed;
                    n_active[i_cmd.channel] = 1'b0;
                    first_vld               = 1'b1;
                end
                dmr_pkg::CMD_RAMP: begin
                    n_target[i_cmd.channel] = i_cmd.speed;
                    n_active[i_cmd.channel] = (r_speed[i_cmd.channel] != i_cmd.speed);
                    n_tick[i_cmd.channel]   = '0;
                end
                dmr_pkg::CMD_BRAKE: begin
                    n_speed[i_cmd.channel]  = braked;
                    n_target[i_cmd.channel] = '0;
                    n_active[i_cmd.channel] = (braked != 8'sd0);
                    n_tick[i_cmd.channel]   = '0;
                    first_vld               = 1'b1;
                end
                dmr_pkg::CMD_TICK: begin
                    for (int c = 0; c < 2; c++) begin
                        if (r_active[c]) begin
                            n_tick[c] = step[c] ? 16'd0 : tick_inc[c];
                            if (step[c]) begin
                                n_speed[c]  = step_speed[c];
                                n_active[c] = (step_speed[c] != r_target[c]);
                            end
                        end
                    end
                    // Channel A goes first; channel B is held for the next cycle
                    priority if (step[0] && step[1]) begin
                        first_vld    = 1'b1;
                        first_ch     = 1'b0;
                        first_last   = 1'b0;
                        n_pend_valid = 1'b1;
                        n_pend_ch    = 1'b1;
                    end else if (step[0]) begin
                        first_vld = 1'b1;
                        first_ch  = 1'b0;
                    end else if (step[1]) begin
                        first_vld = 1'b1;
                        first_ch  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Select the result to write: a held second result wins
    always_comb begin
        if (r_pend_valid) begin
            o_res = dmr_pkg::make_result(r_pend_ch, r_speed[r_pend_ch],
                                         r_active[r_pend_ch], 1'b1);
        end else begin
            o_res = dmr_pkg::make_result(first_ch, n_speed[first_ch],
                                         n_active[first_ch], first_last);
        end
    end

    assign o_res_push = r_pend_valid || first_vld;
    assign o_cmd_pop  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_speed[c]  <= '0;
                r_target[c] <= '0;
                r_active[c] <= 1'b0;
                r_tick[c]   <= '0;
            end
            r_interval   <= dmr_pkg::RAMP_INTERVAL_RESET;
            r_pend_valid <= 1'b0;
            r_pend_ch    <= 1'b0;
        end else begin
            r_speed      <= n_speed;
            r_target     <= n_target;
            r_active     <= n_active;
            r_tick       <= n_tick;
            r_pend_valid <= n_pend_valid;
            r_pend_ch    <= n_pend_ch;
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== sv/dual_motor_ramp_controller_core.sv =====
// Top level of the two-channel motor drive with slew-rate-limited ramps.
`timescale 1ns / 1ps

// Two-channel DC motor drive. Transactions enter through a queue-style port
// (push/full) and results leave through one (empty/pop). Set, stop, ramp, brake
// and tick commands are classified on entry into a command queue; the execution
// stage takes one command per cycle and writes its results into a result queue,
// so a transaction is accepted every cycle while the command queue is not full.
// A tick that steps both channels produces two results and holds the second
// back, taking no command until it is written, since the result queue takes
// one entry per cycle; execution also waits while fewer than two result slots
// are free. Each result carries the channel, direction level, PWM duty, applied
// speed, whether the channel is still ramping, and a flag on the final result
// of its transaction. ramp_interval is written through
// i_cfg_wr_en/i_cfg_wr_data and must only change while the block is idle; a
// value of zero acts as one.

module dual_motor_ramp_controller_core #(
    parameter int CMD_DEPTH = dmr_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = dmr_pkg::OUT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  dmr_pkg::t_in_item  i_in_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output dmr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);

    dmr_pkg::t_cmd      cmd;
    logic               cmd_valid;
    logic               cmd_pop;
    logic               res_push;
    dmr_pkg::t_out_item res;
    logic               out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic [$bits(dmr_pkg::t_out_item)-1:0] out_bits;

    // Accept and classify transactions
    dmr_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid)
    );

    // Execute commands against the channel state
    dmr_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .i_out_count   (out_count),
        .o_res_push    (res_push),
        .o_res         (res)
    );

    // Hold results until popped
    dmr_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(dmr_pkg::t_out_item))
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_push && !out_full),
        .i_wr_data (res),
        .i_pop     (pop),
        .o_rd_data (out_bits),
        .o_empty   (empty),
        .o_full    (out_full),
        .o_count   (out_count)
    );

    assign o_out_item = dmr_pkg::t_out_item'(out_bits);

endmodule
